### rtl/core/hncm_pkg.sv
// Shared types and constants for the hypergraph net connectivity metric.
// No dependencies; used by every module of the block.
package hncm_pkg;

    localparam int PART_W          = 8;
    localparam int CNT_W           = 9;
    localparam int TOT_OUT_W       = 32;
    localparam int MAX_PARTS_DEF   = 256;
    localparam int TOTAL_WIDTH_DEF = 32;
    localparam int EPOCH_W         = 12;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 80;
    localparam int M_TUSER_W       = 2;

    localparam logic [CNT_W-1:0] NUM_PARTS_RST = CNT_W'(256);

    typedef struct packed {
        logic [CNT_W-1:0] parts;
        logic             bad;
    } net_sum_t;

endpackage

### rtl/core/hypergraph_net_connectivity_metric.sv
// Top level of the hypergraph net connectivity metric.
// Depends on hncm_pkg, hncm_tracker and hncm_accum.
//
// Input channel s_*: one pin per item; s_tdata carries the part id,
// s_tlast marks the last pin of a net. Output channel m_*: one item per
// finished net with its connectivity and the running cut and volume totals.
// cfg_we/cfg_wdata write num_parts; write only while the block is idle.
//
// Throughput: one pin per cycle while s_tready is high, set by the single tag
// test-and-set of the tracker. The tag store is cleared in a pass over all
// MAX_PARTS entries (256 by default) after reset and again after every 4095
// nets; s_tready is low throughout the pass. A last pin accepted into the
// input register passes through the result register onto m_tvalid.
//
// Reset clears the counters, totals and the valid bits of both pipeline
// registers, sets num_parts to 256 and starts the clearing pass.
// When the receiver stalls, the result register holds; non-last pins keep
// flowing, and a last pin waits in the input register, after which s_tready
// falls until the result is taken.
module hypergraph_net_connectivity_metric #(
    parameter int MAX_PARTS   = hncm_pkg::MAX_PARTS_DEF,
    parameter int TOTAL_WIDTH = hncm_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hncm_pkg::CNT_W-1:0]     cfg_wdata,    // num_parts
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hncm_pkg::S_TDATA_W-1:0] s_tdata,      // [7:0] pin_part
    input  logic                           s_tlast,      // last_pin
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hncm_pkg::M_TDATA_W-1:0] m_tdata,      // [8:0] net_parts,
                                                         // [40:9] cut_total,
                                                         // [72:41] volume_total
    output logic [hncm_pkg::M_TUSER_W-1:0] m_tuser       // [0] net_is_cut,
                                                         // [1] bad_part_seen
);

    logic [hncm_pkg::CNT_W-1:0]     num_parts_reg;
    logic                           in_vld_reg;
    logic [hncm_pkg::PART_W-1:0]    in_part_reg;
    logic                           in_last_reg;
    logic                           out_vld_reg;
    logic [hncm_pkg::CNT_W-1:0]     out_parts_reg;
    logic                           out_cut_reg;
    logic [hncm_pkg::TOT_OUT_W-1:0] out_ctot_reg;
    logic [hncm_pkg::TOT_OUT_W-1:0] out_vtot_reg;
    logic                           out_bad_reg;
    logic                           out_free;
    logic                           adv;
    logic                           fire;
    logic                           s_acc;
    logic                           clr_busy;
    logic                           is_cut;
    logic [hncm_pkg::TOT_OUT_W-1:0] cut_out;
    logic [hncm_pkg::TOT_OUT_W-1:0] vol_out;
    hncm_pkg::net_sum_t             sum;

    assign out_free = !out_vld_reg || m_tready;
    assign adv      = in_vld_reg && !clr_busy && (!in_last_reg || out_free);
    assign fire     = adv && in_last_reg;
    assign s_tready = !clr_busy && (!in_vld_reg || adv);
    assign s_acc    = s_tvalid && s_tready;

    hncm_tracker #(
        .MAX_PARTS (MAX_PARTS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (s_acc),
        .rd_part   (s_tdata[hncm_pkg::PART_W-1:0]),
        .upd       (adv),
        .part      (in_part_reg),
        .last      (in_last_reg),
        .num_parts (num_parts_reg),
        .sum       (sum),
        .clr_busy  (clr_busy)
    );

    hncm_accum #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .parts   (sum.parts),
        .is_cut  (is_cut),
        .cut_out (cut_out),
        .vol_out (vol_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_parts_reg <= hncm_pkg::NUM_PARTS_RST;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_parts_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            in_part_reg <= s_tdata[hncm_pkg::PART_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (fire)
        begin
            out_parts_reg <= sum.parts;
            out_cut_reg   <= is_cut;
            out_ctot_reg  <= cut_out;
            out_vtot_reg  <= vol_out;
            out_bad_reg   <= sum.bad;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_vtot_reg, out_ctot_reg, out_parts_reg};
    assign m_tuser  = {out_bad_reg, out_cut_reg};

endmodule

### rtl/core/hncm_tracker.sv
// Per-net part tag store, distinct-part counter and bad-id flag.
// Depends on hncm_pkg.
module hncm_tracker #(
    parameter int MAX_PARTS = hncm_pkg::MAX_PARTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [hncm_pkg::PART_W-1:0] rd_part,
    input  logic                        upd,
    input  logic [hncm_pkg::PART_W-1:0] part,
    input  logic                        last,
    input  logic [hncm_pkg::CNT_W-1:0]  num_parts,
    output hncm_pkg::net_sum_t          sum,
    output logic                        clr_busy
);

    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int EXT_W = (IDX_W > hncm_pkg::PART_W) ? IDX_W : hncm_pkg::PART_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PARTS - 1);

    logic [hncm_pkg::EPOCH_W-1:0]   tag_mem [MAX_PARTS];
    logic [hncm_pkg::EPOCH_W-1:0]   tag_rd_reg;
    logic                           fwd_reg;
    logic                           fwd_next;
    logic                           first_reg;
    logic                           first_next;
    logic [hncm_pkg::EPOCH_W-1:0]   epoch_reg;
    logic [hncm_pkg::EPOCH_W-1:0]   epoch_next;
    logic                           clr_busy_reg;
    logic                           clr_busy_next;
    logic [IDX_W-1:0]               clr_ptr_reg;
    logic [IDX_W-1:0]               clr_ptr_next;
    logic [hncm_pkg::CNT_W-1:0]     cnt_reg;
    logic [hncm_pkg::CNT_W-1:0]     cnt_next;
    logic                           bad_reg;
    logic                           bad_next;
    logic [EXT_W-1:0]               part_ext;
    logic [EXT_W-1:0]               rd_ext;
    logic [IDX_W-1:0]               idx;
    logic [IDX_W-1:0]               rd_idx;
    logic                           in_range;
    logic                           seen;
    logic                           is_new;
    logic                           wr_en;
    logic [hncm_pkg::CNT_W-1:0]     cnt_upd;
    logic                           bad_upd;

    assign part_ext = EXT_W'(part);
    assign idx      = part_ext[IDX_W-1:0];
    assign rd_ext   = EXT_W'(rd_part);
    assign rd_idx   = rd_ext[IDX_W-1:0];
    assign in_range = ({1'b0, part} < num_parts) && (32'(part) < 32'(MAX_PARTS));
    assign seen     = !first_reg && (fwd_reg || (tag_rd_reg == epoch_reg));
    assign is_new   = in_range && !seen;
    assign wr_en    = upd && !last && is_new;
    assign cnt_upd  = cnt_reg + hncm_pkg::CNT_W'(is_new);
    assign bad_upd  = bad_reg || !in_range;

    assign sum.parts = cnt_upd;
    assign sum.bad   = bad_upd;
    assign clr_busy  = clr_busy_reg;

    always_comb
    begin
        cnt_next      = cnt_reg;
        bad_next      = bad_reg;
        epoch_next    = epoch_reg;
        clr_busy_next = clr_busy_reg;
        clr_ptr_next  = clr_ptr_reg;
        fwd_next      = fwd_reg;
        first_next    = first_reg;
        if (upd)
        begin
            if (last)
            begin
                cnt_next = '0;
                bad_next = 1'b0;
                if (epoch_reg == '1)
                begin
                    epoch_next    = hncm_pkg::EPOCH_W'(1);
                    clr_busy_next = 1'b1;
                    clr_ptr_next  = '0;
                end
                else
                begin
                    epoch_next = epoch_reg + hncm_pkg::EPOCH_W'(1);
                end
            end
            else
            begin
                cnt_next = cnt_upd;
                bad_next = bad_upd;
            end
        end
        if (clr_busy_reg)
        begin
            if (clr_ptr_reg == LAST_IDX)
            begin
                clr_busy_next = 1'b0;
                clr_ptr_next  = '0;
            end
            else
            begin
                clr_ptr_next = clr_ptr_reg + IDX_W'(1);
            end
        end
        if (rd_en)
        begin
            fwd_next   = wr_en && (rd_idx == idx);
            first_next = upd && last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            bad_reg      <= 1'b0;
            epoch_reg    <= hncm_pkg::EPOCH_W'(1);
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
            fwd_reg      <= 1'b0;
            first_reg    <= 1'b1;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            bad_reg      <= bad_next;
            epoch_reg    <= epoch_next;
            clr_busy_reg <= clr_busy_next;
            clr_ptr_reg  <= clr_ptr_next;
            fwd_reg      <= fwd_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            tag_mem[clr_ptr_reg] <= '0;
        end
        else if (wr_en)
        begin
            tag_mem[idx] <= epoch_reg;
        end
        if (rd_en)
        begin
            tag_rd_reg <= tag_mem[rd_idx];
        end
    end

endmodule

### rtl/core/hncm_accum.sv
// Saturating running totals: cut-net count and connectivity-minus-one volume.
// Depends on hncm_pkg.
module hncm_accum #(
    parameter int TOTAL_WIDTH = hncm_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [hncm_pkg::CNT_W-1:0]     parts,
    output logic                           is_cut,
    output logic [hncm_pkg::TOT_OUT_W-1:0] cut_out,
    output logic [hncm_pkg::TOT_OUT_W-1:0] vol_out
);

    logic [TOTAL_WIDTH-1:0] cut_reg;
    logic [TOTAL_WIDTH-1:0] cut_next;
    logic [TOTAL_WIDTH-1:0] vol_reg;
    logic [TOTAL_WIDTH-1:0] vol_next;
    logic [TOTAL_WIDTH:0]   cut_sum;
    logic [TOTAL_WIDTH:0]   vol_sum;
    logic [TOTAL_WIDTH-1:0] cut_new;
    logic [TOTAL_WIDTH-1:0] vol_new;

    assign is_cut  = parts > hncm_pkg::CNT_W'(1);
    assign cut_sum = {1'b0, cut_reg} + (TOTAL_WIDTH+1)'(1);
    assign vol_sum = {1'b0, vol_reg} + (TOTAL_WIDTH+1)'(parts - hncm_pkg::CNT_W'(1));
    assign cut_new = cut_sum[TOTAL_WIDTH] ? '1 : cut_sum[TOTAL_WIDTH-1:0];
    assign vol_new = vol_sum[TOTAL_WIDTH] ? '1 : vol_sum[TOTAL_WIDTH-1:0];

    always_comb
    begin
        cut_next = cut_reg;
        vol_next = vol_reg;
        if (fire && is_cut)
        begin
            cut_next = cut_new;
            vol_next = vol_new;
        end
    end

    assign cut_out = hncm_pkg::TOT_OUT_W'(cut_next);
    assign vol_out = hncm_pkg::TOT_OUT_W'(vol_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_reg <= '0;
            vol_reg <= '0;
        end
        else
        begin
            cut_reg <= cut_next;
            vol_reg <= vol_next;
        end
    end

endmodule

### rtl/core/hncm_checker.sv
// Port-level checks for the hypergraph net connectivity metric.
// Depends on hncm_pkg; bound to the top level below.
module hncm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hncm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [hncm_pkg::M_TUSER_W-1:0] m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_cut_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] == (m_tdata[8:0] > 9'd1))
        else $error("cut flag disagrees with connectivity");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
        else $error("result item carries unknown bits");

    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(s_tready))
        else $error("input ready unknown");

endmodule

bind hypergraph_net_connectivity_metric hncm_checker u_hncm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
